// ===== hw/rtl/arpc_pkg.sv =====
// ----------------------------------------------------------------------------
// arpc_pkg
// shared widths, command and status codes and the table entry layout
// ----------------------------------------------------------------------------
package arpc_pkg;

	localparam int CMD_W     = 2;
	localparam int IP_W      = 32;
	localparam int MAC_W     = 48;
	localparam int STATUS_W  = 3;
	localparam int SLOT_W    = 10;
	localparam int STAMP_W   = 16;
	localparam int TIMEOUT_W = 15;

	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 15'd15;

	typedef logic [CMD_W-1:0]    cmd_t;
	typedef logic [STATUS_W-1:0] status_t;

	localparam cmd_t CMD_LOOKUP = 2'd0;
	localparam cmd_t CMD_INSERT = 2'd1;
	localparam cmd_t CMD_TICK   = 2'd2;

	localparam status_t ST_MISS      = 3'd0;
	localparam status_t ST_HIT       = 3'd1;
	localparam status_t ST_INSERTED  = 3'd2;
	localparam status_t ST_FULL      = 3'd3;
	localparam status_t ST_TICK_DONE = 3'd4;

	// one table entry as held in the memory word
	typedef struct packed {
		logic               valid;
		logic [IP_W-1:0]    ip;
		logic [MAC_W-1:0]   mac;
		logic [STAMP_W-1:0] stamp;
	} entry_t;

endpackage

// ===== hw/rtl/arpc_req_if.sv =====
// ----------------------------------------------------------------------------
// arpc_req_if
// request channel: command, address and mac with valid/ready
// ----------------------------------------------------------------------------
interface arpc_req_if;
	logic                           valid;
	logic                           ready;
	logic [arpc_pkg::CMD_W-1:0]     cmd;
	logic [arpc_pkg::IP_W-1:0]      ip_address;
	logic [arpc_pkg::MAC_W-1:0]     mac_address;

	modport source (output valid, output cmd, output ip_address, output mac_address,
		input ready);
	modport sink (input valid, input cmd, input ip_address, input mac_address,
		output ready);
endinterface

// ===== hw/rtl/arpc_rsp_if.sv =====
// ----------------------------------------------------------------------------
// arpc_rsp_if
// response channel: status, mac and slot with valid/ready
// ----------------------------------------------------------------------------
interface arpc_rsp_if;
	logic                            valid;
	logic                            ready;
	logic [arpc_pkg::STATUS_W-1:0]   status;
	logic [arpc_pkg::MAC_W-1:0]      mac_found;
	logic [arpc_pkg::SLOT_W-1:0]     slot_index;

	modport source (output valid, output status, output mac_found, output slot_index,
		input ready);
	modport sink (input valid, input status, input mac_found, input slot_index,
		output ready);
endinterface

// ===== hw/rtl/arp_cache_table_with_aging_core.sv =====
// ----------------------------------------------------------------------------
// arp_cache_table_with_aging_core
// ipv4 to mac cache with insertion time stamps and timeout aging
// ----------------------------------------------------------------------------
//  channel | dir | handshake       | payload
//  --------+-----+-----------------+--------------------------------------
//  req     | in  | valid/ready     | cmd, ip_address, mac_address
//  rsp     | out | valid/ready     | status, mac_found, slot_index
//  cfg     | in  | cfg_we (no ack) | cfg_wdata = timeout_seconds
//
//  each lookup, insert or tick scans the table through one read port;
//  an insert that finds a free slot writes it after the scan, and an
//  unused command answers without a scan
//  after reset a clearing pass zeroes the table first
//  an output register holds a stalled response while the next request is
//  taken; a finished scan waits for that register to free up
// ----------------------------------------------------------------------------
module arp_cache_table_with_aging_core #(
	parameter int ENTRIES = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	arpc_req_if.sink                         req,
	arpc_rsp_if.source                       rsp,
	input  logic                             cfg_we,
	input  logic [arpc_pkg::TIMEOUT_W-1:0]   cfg_wdata
);

	// index of a table slot, and a scan counter that can also hold ENTRIES
	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam logic [CNT_W-1:0] SCAN_END  = CNT_W'(ENTRIES);
	localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(ENTRIES - 1);

	typedef enum logic [4:0] {
		S_CLEAR = 5'b00001,
		S_IDLE  = 5'b00010,
		S_SCAN  = 5'b00100,
		S_WRITE = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

	state_t state_q;

	// scan control
	logic [CNT_W-1:0] cnt_q;
	logic             pend_s1;
	logic [IDX_W-1:0] idx_s1;

	// current transaction and its partial result
	arpc_pkg::cmd_t                 op_q;
	logic [arpc_pkg::IP_W-1:0]      ip_q;
	logic [arpc_pkg::MAC_W-1:0]     mac_q;
	logic                           hit_q;
	logic                           found_q;
	logic [IDX_W-1:0]               res_idx_q;
	logic [arpc_pkg::MAC_W-1:0]     res_mac_q;

	logic [arpc_pkg::STAMP_W-1:0]   sec_q;
	logic [arpc_pkg::TIMEOUT_W-1:0] timeout_q;

	// response register
	logic                           out_valid_q;
	arpc_pkg::status_t              out_status_q;
	logic [arpc_pkg::MAC_W-1:0]     out_mac_q;
	logic [arpc_pkg::SLOT_W-1:0]    out_slot_q;

	// memory ports
	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	arpc_pkg::entry_t mem_wdata;
	logic             mem_re;
	logic [IDX_W-1:0] mem_raddr;
	arpc_pkg::entry_t mem_rdata;

	logic                           req_acc;
	logic                           scan_done;
	logic                           out_free;
	logic [arpc_pkg::STAMP_W-1:0]   age;
	logic                           expire;
	arpc_pkg::status_t              res_status;
	logic [arpc_pkg::MAC_W-1:0]     res_mac;
	logic [arpc_pkg::SLOT_W-1:0]    res_slot;

	assign req.ready = (state_q == S_IDLE);
	assign req_acc   = req.valid && req.ready;
	assign out_free  = !out_valid_q || rsp.ready;

	// reads walk the table in order, one slot a cycle
	assign mem_re    = (state_q == S_SCAN) && (cnt_q < SCAN_END);
	assign mem_raddr = cnt_q[IDX_W-1:0];
	assign scan_done = (state_q == S_SCAN) && (cnt_q == SCAN_END) && !pend_s1;

	// wrapping age against the already advanced second count
	assign age    = sec_q - mem_rdata.stamp;
	assign expire = pend_s1 && (op_q == arpc_pkg::CMD_TICK) && mem_rdata.valid
		&& (age > {1'b0, timeout_q});

	// write port: clearing pass, tick write-back of expired slots, insert.
	// each slot is read and written back once per scan, so no two accesses
	// to the same slot overlap
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_s1;
		mem_wdata = '0;
		if (state_q == S_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = cnt_q[IDX_W-1:0];
		end else if (state_q == S_WRITE) begin
			mem_we          = 1'b1;
			mem_waddr       = res_idx_q;
			mem_wdata.valid = 1'b1;
			mem_wdata.ip    = ip_q;
			mem_wdata.mac   = mac_q;
			mem_wdata.stamp = sec_q;
		end else if (expire) begin
			mem_we = 1'b1;
		end
	end

	arpc_mem #(
		.DEPTH (ENTRIES),
		.AW    (IDX_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// response fields from the finished scan
	always_comb begin
		res_status = arpc_pkg::ST_MISS;
		res_mac    = '0;
		res_slot   = '0;
		case (op_q)
			arpc_pkg::CMD_LOOKUP: begin
				if (hit_q) begin
					res_status         = arpc_pkg::ST_HIT;
					res_mac            = res_mac_q;
					res_slot[IDX_W-1:0] = res_idx_q;
				end
			end
			arpc_pkg::CMD_INSERT: begin
				if (found_q) begin
					res_status          = arpc_pkg::ST_INSERTED;
					res_slot[IDX_W-1:0] = res_idx_q;
				end else begin
					res_status = arpc_pkg::ST_FULL;
				end
			end
			arpc_pkg::CMD_TICK: begin
				res_status = arpc_pkg::ST_TICK_DONE;
			end
			default: begin
				res_status = arpc_pkg::ST_MISS;
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			cnt_q     <= '0;
			pend_s1   <= 1'b0;
			sec_q     <= '0;
			timeout_q <= arpc_pkg::TIMEOUT_RESET;
			hit_q     <= 1'b0;
			found_q   <= 1'b0;
			op_q      <= arpc_pkg::CMD_LOOKUP;
		end else begin
			pend_s1 <= mem_re;
			if (cfg_we) begin
				timeout_q <= cfg_wdata;
			end
			case (state_q)
				S_CLEAR: begin
					if (cnt_q[IDX_W-1:0] == LAST_SLOT) begin
						cnt_q   <= '0;
						state_q <= S_IDLE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (req_acc) begin
						op_q    <= req.cmd;
						hit_q   <= 1'b0;
						found_q <= 1'b0;
						cnt_q   <= '0;
						if (req.cmd == arpc_pkg::CMD_TICK) begin
							sec_q <= sec_q + 1'b1;
						end
						if (req.cmd inside {arpc_pkg::CMD_LOOKUP, arpc_pkg::CMD_INSERT,
							arpc_pkg::CMD_TICK}) begin
							state_q <= S_SCAN;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_SCAN: begin
					if (mem_re) begin
						cnt_q <= cnt_q + 1'b1;
					end
					if (pend_s1) begin
						// last match wins on lookup, first free slot wins on insert
						if (op_q == arpc_pkg::CMD_LOOKUP && mem_rdata.valid
							&& mem_rdata.ip == ip_q) begin
							hit_q <= 1'b1;
						end
						if (op_q == arpc_pkg::CMD_INSERT && !mem_rdata.valid) begin
							found_q <= 1'b1;
						end
					end
					if (scan_done) begin
						if (op_q == arpc_pkg::CMD_INSERT && found_q) begin
							state_q <= S_WRITE;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_WRITE: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// transaction payload and scan results
	always_ff @(posedge clk) begin
		if (req_acc) begin
			ip_q      <= req.ip_address;
			mac_q     <= req.mac_address;
			res_idx_q <= '0;
			res_mac_q <= '0;
		end
		idx_s1 <= mem_raddr;
		if (state_q == S_SCAN && pend_s1) begin
			if (op_q == arpc_pkg::CMD_LOOKUP && mem_rdata.valid && mem_rdata.ip == ip_q) begin
				res_idx_q <= idx_s1;
				res_mac_q <= mem_rdata.mac;
			end
			if (op_q == arpc_pkg::CMD_INSERT && !mem_rdata.valid && !found_q) begin
				res_idx_q <= idx_s1;
			end
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			out_status_q <= res_status;
			out_mac_q    <= res_mac;
			out_slot_q   <= res_slot;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.status     = out_status_q;
	assign rsp.mac_found  = out_mac_q;
	assign rsp.slot_index = out_slot_q;

endmodule

// ===== hw/rtl/arpc_mem.sv =====
// ----------------------------------------------------------------------------
// arpc_mem
// single-port-write, single-port-read table memory with registered read data
// ----------------------------------------------------------------------------
module arpc_mem #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  arpc_pkg::entry_t wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output arpc_pkg::entry_t rdata
);

	arpc_pkg::entry_t mem_q [DEPTH];
	arpc_pkg::entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/arpc_checker.sv =====
// ----------------------------------------------------------------------------
// arpc_checker
// port-level checks of the cache responses, bound to the core
// ----------------------------------------------------------------------------
module arpc_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            req_valid,
	input logic                            req_ready,
	input logic                            rsp_valid,
	input logic                            rsp_ready,
	input logic [arpc_pkg::STATUS_W-1:0]   rsp_status,
	input logic [arpc_pkg::MAC_W-1:0]      rsp_mac,
	input logic [arpc_pkg::SLOT_W-1:0]     rsp_slot
);

	// requests taken minus responses delivered
	logic [1:0] open_q;
	logic       req_acc;
	logic       rsp_acc;

	assign req_acc = req_valid && req_ready;
	assign rsp_acc = rsp_valid && rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= '0;
		end else if (req_acc && !rsp_acc) begin
			open_q <= open_q + 1'b1;
		end else if (rsp_acc && !req_acc) begin
			open_q <= open_q - 1'b1;
		end
	end

	a_no_extra_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> open_q != 2'd0)
		else $error("response without an open request");

	a_open_bound: assert property (@(posedge clk) disable iff (!arst_n)
		open_q != 2'd3)
		else $error("too many requests in flight");

	a_mac_only_on_hit: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != arpc_pkg::ST_HIT |-> rsp_mac == '0)
		else $error("mac reported without a hit");

	a_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status == arpc_pkg::ST_MISS || rsp_status == arpc_pkg::ST_FULL
		|| rsp_status == arpc_pkg::ST_TICK_DONE) |-> rsp_slot == '0)
		else $error("slot reported for miss, full or tick");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_slot))
		else $error("stalled response changed");

endmodule

bind arp_cache_table_with_aging_core arpc_checker u_arpc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_status (rsp.status),
	.rsp_mac    (rsp.mac_found),
	.rsp_slot   (rsp.slot_index)
);

// ===== dv/tb_arp_cache_table_with_aging_core.sv =====
// ----------------------------------------------------------------------------
// tb_arp_cache_table_with_aging_core
// self-checking bench for the ip to mac cache with timeout aging
//
// A short directed table covers the field extremes, every command, duplicate
// inserts and expiry with the smallest lifetimes. Random phases follow, each
// with its own timeout, command mix and idle and stall pattern. Their
// addresses come from a small pool, so lookups hit, duplicates pile up and
// the table fills. A behavioral copy of the table predicts every response.
// ----------------------------------------------------------------------------
module tb_arp_cache_table_with_aging_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ENTRIES          = 64;
	localparam int CLK_HALF         = 5;
	localparam int RESET_CYCLES     = 5;
	localparam int SETTLE_CYCLES    = 4;           // pause before a timeout write
	localparam int DRAIN_CYCLES     = ENTRIES + 8; // a full scan plus margin
	localparam int CYCLE_LIMIT      = 1_000_000;
	localparam int PHASES           = 6;
	localparam int ITEMS_PER_PHASE  = 150;
	localparam int POOL_SIZE        = 12;

	// the block answers this code like a lookup miss and leaves the table alone
	localparam arpc_pkg::cmd_t CMD_UNUSED = 2'd3;

	typedef logic [arpc_pkg::IP_W-1:0]      ip_t;
	typedef logic [arpc_pkg::MAC_W-1:0]     mac_t;
	typedef logic [arpc_pkg::SLOT_W-1:0]    slot_t;
	typedef logic [arpc_pkg::STAMP_W-1:0]   stamp_t;
	typedef logic [arpc_pkg::TIMEOUT_W-1:0] timeout_t;

	typedef struct packed {
		arpc_pkg::status_t status;
		mac_t              mac_found;
		slot_t             slot_index;
	} arp_result_t;

	// a directed row is either a request or a timeout write
	typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t      kind;
		arpc_pkg::cmd_t cmd;
		ip_t            ip;
		mac_t           mac;
		timeout_t       timeout;
		logic           known;  // expected response typed in below
		arp_result_t    res;
	} dir_row_t;

	typedef struct packed {
		int       send_idle;
		int       recv_stall;
		timeout_t timeout;
		int       insert_pct;
		int       tick_pct;
	} phase_t;

	// slots 0..2 are stamped 0, slot 3 at second 1; the lifetime then shrinks
	// to one tick and to zero so that expiry shows up within a few ticks
	localparam dir_row_t DIRECTED [24] = '{
		'{ROW_REQ, arpc_pkg::CMD_LOOKUP, 32'h0000_0000, 48'h0000_0000_0000, 15'd0, 1'b1,
			'{arpc_pkg::ST_MISS, 48'h0, 10'd0}},
		'{ROW_REQ, arpc_pkg::CMD_INSERT, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 15'd0, 1'b1,
			'{arpc_pkg::ST_INSERTED, 48'h0, 10'd0}},
		'{ROW_REQ, arpc_pkg::CMD_INSERT, 32'h0000_0000, 48'h0000_0000_0000, 15'd0, 1'b1,
			'{arpc_pkg::ST_INSERTED, 48'h0, 10'd1}},
		'{ROW_REQ, arpc_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, 48'h0000_0000_0000, 15'd0, 1'b1,
			'{arpc_pkg::ST_HIT, 48'hFFFF_FFFF_FFFF, 10'd0}},
		'{ROW_REQ, arpc_pkg::CMD_LOOKUP, 32'h0000_0000, 48'hFFFF_FFFF_FFFF, 15'd0, 1'b1,
			'{arpc_pkg::ST_HIT, 48'h0, 10'd1}},
		// duplicate address: the higher slot wins from now on
		'{ROW_REQ, arpc_pkg::CMD_INSERT, 32'hFFFF_FFFF, 48'h0123_4567_89AB, 15'd0, 1'b1,
			'{arpc_pkg::ST_INSERTED, 48'h0, 10'd2}},
		'{ROW_REQ, arpc_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, 48'h0000_0000_0000, 15'd0, 1'b1,
			'{arpc_pkg::ST_HIT, 48'h0123_4567_89AB, 10'd2}},
		'{ROW_REQ, CMD_UNUSED, 32'h8000_0001, 48'h8000_0000_0001, 15'd0, 1'b1,
			'{arpc_pkg::ST_MISS, 48'h0, 10'd0}},
		'{ROW_REQ, arpc_pkg::CMD_TICK,   32'h5555_5555, 48'hAAAA_AAAA_AAAA, 15'd0, 1'b1,
			'{arpc_pkg::ST_TICK_DONE, 48'h0, 10'd0}},
		'{ROW_REQ, arpc_pkg::CMD_INSERT, 32'h1234_5678, 48'h5A5A_5A5A_5A5A, 15'd0, 1'b1,
			'{arpc_pkg::ST_INSERTED, 48'h0, 10'd3}},
		'{ROW_CFG, arpc_pkg::CMD_LOOKUP, 32'h0, 48'h0, 15'd1, 1'b0, '0},
		'{ROW_REQ, arpc_pkg::CMD_TICK,   32'h0000_0000, 48'h0000_0000_0000, 15'd0, 1'b1,
			'{arpc_pkg::ST_TICK_DONE, 48'h0, 10'd0}},
		'{ROW_REQ, arpc_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, 48'h0, 15'd0, 1'b0, '0},
		'{ROW_REQ, arpc_pkg::CMD_LOOKUP, 32'h1234_5678, 48'h0, 15'd0, 1'b0, '0},
		'{ROW_REQ, arpc_pkg::CMD_INSERT, 32'hA5A5_5A5A, 48'h8000_0000_0000, 15'd0, 1'b0, '0},
		'{ROW_REQ, arpc_pkg::CMD_TICK,   32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 15'd0, 1'b1,
			'{arpc_pkg::ST_TICK_DONE, 48'h0, 10'd0}},
		'{ROW_REQ, arpc_pkg::CMD_LOOKUP, 32'h1234_5678, 48'h0, 15'd0, 1'b0, '0},
		'{ROW_REQ, arpc_pkg::CMD_LOOKUP, 32'hA5A5_5A5A, 48'h0, 15'd0, 1'b0, '0},
		'{ROW_CFG, arpc_pkg::CMD_LOOKUP, 32'h0, 48'h0, 15'd0, 1'b0, '0},
		'{ROW_REQ, arpc_pkg::CMD_INSERT, 32'h0000_0001, 48'h0000_0000_0001, 15'd0, 1'b0, '0},
		'{ROW_REQ, arpc_pkg::CMD_TICK,   32'h0000_0000, 48'h0000_0000_0000, 15'd0, 1'b1,
			'{arpc_pkg::ST_TICK_DONE, 48'h0, 10'd0}},
		'{ROW_REQ, arpc_pkg::CMD_LOOKUP, 32'h0000_0001, 48'h0, 15'd0, 1'b0, '0},
		'{ROW_REQ, arpc_pkg::CMD_LOOKUP, 32'hA5A5_5A5A, 48'h0, 15'd0, 1'b0, '0},
		'{ROW_CFG, arpc_pkg::CMD_LOOKUP, 32'h0, 48'h0, 15'h7FFF, 1'b0, '0}
	};

	// idle pattern, lifetime and command mix of each random phase
	localparam phase_t PHASE_PLAN [PHASES] = '{
		'{0,  0,  15'h7FFF, 55, 5},   // fills the table, then drops inserts
		'{88, 0,  15'd1,    35, 25},
		'{0,  88, 15'd20,   40, 15},
		'{11, 11, 15'd0,    40, 15},
		'{11, 11, 15'd37,   45, 10},
		'{0,  0,  15'd15,   50, 10}
	};

	logic     clk = 1'b0;
	logic     arst_n;
	logic     cfg_we;
	timeout_t cfg_wdata;
	logic     rsp_accept = 1'b0;

	arpc_req_if req_ch();
	arpc_rsp_if rsp_ch();

	assign rsp_ch.ready = rsp_accept;

	arp_cache_table_with_aging_core #(
		.ENTRIES(ENTRIES)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #CLK_HALF clk = ~clk;

	// behavioral copy of the table
	logic     tbl_valid [ENTRIES];
	ip_t      tbl_ip    [ENTRIES];
	mac_t     tbl_mac   [ENTRIES];
	stamp_t   tbl_stamp [ENTRIES];
	stamp_t   seconds;
	timeout_t lifetime;

	arp_result_t expected_q [$];
	ip_t         ip_pool [POOL_SIZE];

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int mismatches     = 0;
	int cycle_count    = 0;

	// coverage tallies for the closing summary
	int n_items, n_hit, n_miss, n_insert, n_full, n_tick, n_expired, n_unused, n_cfg;

	// apply one command to the table copy and return the response it gives
	function automatic arp_result_t cache_apply(arpc_pkg::cmd_t cmd, ip_t ip, mac_t mac);
		arp_result_t res;
		int          hit_slot;
		int          free_slot;
		stamp_t      age;

		res       = '0;
		hit_slot  = -1;
		free_slot = -1;
		case (cmd)
			arpc_pkg::CMD_LOOKUP: begin
				// last match in index order is the highest one
				for (int i = 0; i < ENTRIES; i++)
					if (tbl_valid[i] && tbl_ip[i] == ip)
						hit_slot = i;
				if (hit_slot >= 0) begin
					res.status     = arpc_pkg::ST_HIT;
					res.mac_found  = tbl_mac[hit_slot];
					res.slot_index = slot_t'(hit_slot);
					n_hit++;
				end else begin
					res.status = arpc_pkg::ST_MISS;
					n_miss++;
				end
			end
			arpc_pkg::CMD_INSERT: begin
				for (int i = ENTRIES - 1; i >= 0; i--)
					if (!tbl_valid[i])
						free_slot = i;
				if (free_slot >= 0) begin
					tbl_valid[free_slot] = 1'b1;
					tbl_ip[free_slot]    = ip;
					tbl_mac[free_slot]   = mac;
					tbl_stamp[free_slot] = seconds;
					res.status           = arpc_pkg::ST_INSERTED;
					res.slot_index       = slot_t'(free_slot);
					n_insert++;
				end else begin
					res.status = arpc_pkg::ST_FULL;
					n_full++;
				end
			end
			arpc_pkg::CMD_TICK: begin
				// advance first, then age out with a wrapping difference
				seconds = seconds + 1'b1;
				for (int i = 0; i < ENTRIES; i++) begin
					if (tbl_valid[i]) begin
						age = seconds - tbl_stamp[i];
						if (age > stamp_t'(lifetime)) begin
							tbl_valid[i] = 1'b0;
							n_expired++;
						end
					end
				end
				res.status = arpc_pkg::ST_TICK_DONE;
				n_tick++;
			end
			default: begin
				res.status = arpc_pkg::ST_MISS;
				n_unused++;
			end
		endcase
		return res;
	endfunction

	// mostly pool addresses so lookups hit; now and then the extremes or noise
	function automatic ip_t pick_ip();
		int r;

		r = $urandom_range(99);
		if (r < 3)
			return '0;
		if (r < 6)
			return '1;
		if (r < 85)
			return ip_pool[$urandom_range(POOL_SIZE - 1)];
		return ip_t'($urandom());
	endfunction

	function automatic mac_t pick_mac();
		case ($urandom_range(15))
			0:       return '0;
			1:       return '1;
			default: return {16'($urandom()), 32'($urandom())};
		endcase
	endfunction

	// present one request, hold it until the transaction happens, then predict;
	// valid stays high on return so back-to-back requests need no second update
	task automatic send_request(arpc_pkg::cmd_t cmd, ip_t ip, mac_t mac, logic known,
			arp_result_t known_res);
		arp_result_t predicted;

		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.cmd         <= cmd;
		req_ch.ip_address  <= ip;
		req_ch.mac_address <= mac;
		do
			@(posedge clk);
		while (!req_ch.ready);
		predicted = cache_apply(cmd, ip, mac);
		expected_q.push_back(known ? known_res : predicted);
		n_items++;
	endtask

	// the timeout register is only written with the block drained
	task automatic set_timeout(timeout_t value);
		req_ch.valid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we   <= 1'b0;
		lifetime  = value;
		n_cfg++;
	endtask

	// response side: random backpressure and in-order compare
	always @(posedge clk) begin : rsp_check
		arp_result_t want;

		rsp_accept <= ($urandom_range(99) >= recv_stall_pct);
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_q.size() == 0) begin
				$display("%0t: response with none expected: status %0d mac %h slot %0d",
					$time, rsp_ch.status, rsp_ch.mac_found, rsp_ch.slot_index);
				mismatches++;
			end else begin
				want = expected_q.pop_front();
				if (rsp_ch.status !== want.status) begin
					$display("%0t: status expected %0d actual %0d",
						$time, want.status, rsp_ch.status);
					mismatches++;
				end
				if (rsp_ch.mac_found !== want.mac_found) begin
					$display("%0t: mac_found expected %h actual %h",
						$time, want.mac_found, rsp_ch.mac_found);
					mismatches++;
				end
				if (rsp_ch.slot_index !== want.slot_index) begin
					$display("%0t: slot_index expected %0d actual %0d",
						$time, want.slot_index, rsp_ch.slot_index);
					mismatches++;
				end
			end
		end
	end

	// watchdog, far above the slowest legal run including the clearing pass
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t: no progress after %0d cycles, %0d responses outstanding",
				$time, cycle_count, expected_q.size());
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		dir_row_t       row;
		phase_t         plan;
		arpc_pkg::cmd_t cmd;
		int             r;

		// table copy at reset: nothing valid, counter and lifetime at defaults
		foreach (tbl_valid[i])
			tbl_valid[i] = 1'b0;
		seconds  = '0;
		lifetime = arpc_pkg::TIMEOUT_RESET;

		arst_n             <= 1'b0;
		cfg_we             <= 1'b0;
		cfg_wdata          <= '0;
		req_ch.valid       <= 1'b0;
		req_ch.cmd         <= arpc_pkg::CMD_LOOKUP;
		req_ch.ip_address  <= '0;
		req_ch.mac_address <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows, no idling on either side
		foreach (DIRECTED[k]) begin
			row = DIRECTED[k];
			if (row.kind == ROW_CFG)
				set_timeout(row.timeout);
			else
				send_request(row.cmd, row.ip, row.mac, row.known, row.res);
		end

		// random phases; the table carries over from one to the next
		for (int p = 0; p < PHASES; p++) begin
			plan = PHASE_PLAN[p];
			set_timeout(plan.timeout);
			send_idle_pct  = plan.send_idle;
			recv_stall_pct = plan.recv_stall;
			foreach (ip_pool[i])
				ip_pool[i] = ip_t'($urandom());
			repeat (ITEMS_PER_PHASE) begin
				r = $urandom_range(99);
				if (r < 4)
					cmd = CMD_UNUSED;
				else if (r < 4 + plan.insert_pct)
					cmd = arpc_pkg::CMD_INSERT;
				else if (r < 4 + plan.insert_pct + plan.tick_pct)
					cmd = arpc_pkg::CMD_TICK;
				else
					cmd = arpc_pkg::CMD_LOOKUP;
				send_request(cmd, pick_ip(), pick_mac(), 1'b0, '0);
			end
		end
		req_ch.valid <= 1'b0;

		// drain, then give any stray response time to show up
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d requests over %0d timeout settings: %0d hits, %0d misses, %0d inserts,",
			n_items, n_cfg, n_hit, n_miss, n_insert);
		$display("%0d inserts refused on a full table, %0d ticks aging out %0d entries,",
			n_full, n_tick, n_expired);
		$display("%0d unused commands", n_unused);
		if (mismatches == 0 && expected_q.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
